FILE: hw/rtl/tick_driven_uart_with_fifos_macros.svh
// ----------------------------------------------------------------------------
// UART assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_UART_WITH_FIFOS_MACROS_SVH
`define TICK_DRIVEN_UART_WITH_FIFOS_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define TDU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define TDU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tduart_pkg.sv
// ----------------------------------------------------------------------------
// UART package
// Shared types and constants of the tick-paced UART with transmit and
// receive rings.
// ----------------------------------------------------------------------------
`default_nettype none

package tduart_pkg;

	localparam int TX_RING_DEPTH = 16;
	localparam int RX_RING_DEPTH = 16;
	localparam int TX_PW         = $clog2(TX_RING_DEPTH);
	localparam int RX_PW         = $clog2(RX_RING_DEPTH);

	localparam logic [3:0] FRAME_BITS   = 4'd10;
	localparam logic [3:0] DATA_BITS    = 4'd8;
	localparam logic [7:0] START_GAP    = 8'd4;
	localparam logic [7:0] PERIOD_RESET = 8'd5;

	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_POP  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       rx_line;
		logic [7:0] tx_byte;
	} item_t;

	// Declared from the highest field down so that tx_line sits at bit 0.
	typedef struct packed {
		logic [3:0] tx_pending;
		logic [3:0] rx_count;
		logic [7:0] rx_byte;
		logic       pop_valid;
		logic       push_accepted;
		logic       tx_line;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

FILE: hw/rtl/tduart_obuf.sv
// ----------------------------------------------------------------------------
// UART result buffer
// Two-entry output register with skid stage; the ready towards the core is
// taken from a register.
// ----------------------------------------------------------------------------
`default_nettype none

module tduart_obuf (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire tduart_pkg::result_t       in_res,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output tduart_pkg::result_t            out_res
);

	logic                out_v_q;
	logic                skid_v_q;
	tduart_pkg::result_t out_d_q;
	tduart_pkg::result_t skid_d_q;
	logic                take_in;
	logic                drain;

	assign in_ready  = !skid_v_q;
	assign take_in   = in_valid && in_ready;
	assign drain     = out_v_q && out_ready;
	assign out_valid = out_v_q;
	assign out_res   = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			priority if (drain && skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else if (drain || !out_v_q) begin
				out_v_q <= take_in;
			end else if (take_in) begin
				skid_v_q <= 1'b1;
			end else begin
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (drain && skid_v_q) begin
			out_d_q <= skid_d_q;
		end else if (drain || !out_v_q) begin
			out_d_q <= in_res;
		end else if (take_in) begin
			skid_d_q <= in_res;
		end else begin
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tduart_core.sv
// ----------------------------------------------------------------------------
// UART core
// Transmitter, receiver, both rings and the bit period register; one word
// updates all of this state but the bit period register together.
// ----------------------------------------------------------------------------
`default_nettype none

module tduart_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 adv,
	input  wire tduart_pkg::item_t    item,
	output tduart_pkg::result_t       res
);

	localparam int TxPw = tduart_pkg::TX_PW;
	localparam int RxPw = tduart_pkg::RX_PW;
	localparam logic [TxPw-1:0] TxLast   = TxPw'(tduart_pkg::TX_RING_DEPTH - 1);
	localparam logic [RxPw-1:0] RxLast   = RxPw'(tduart_pkg::RX_RING_DEPTH - 1);
	localparam logic [TxPw:0]   TxDepthW = (TxPw + 1)'(tduart_pkg::TX_RING_DEPTH);
	localparam logic [RxPw:0]   RxDepthW = (RxPw + 1)'(tduart_pkg::RX_RING_DEPTH);

	logic [7:0] bit_period_q;

	logic [7:0]      tx_ring_q [tduart_pkg::TX_RING_DEPTH];
	logic [7:0]      rx_ring_q [tduart_pkg::RX_RING_DEPTH];
	logic [TxPw-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic [RxPw-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TxPw-1:0] tx_head_inc, tx_tail_inc;
	logic [RxPw-1:0] rx_head_inc, rx_tail_inc;

	logic [9:0] tx_shift_q, tx_shift_d;
	logic [3:0] tx_bits_q, tx_bits_d, tx_bits_dec;
	logic [7:0] tx_cd_q, tx_cd_d, tx_cd_dec;
	logic       tx_active_q, tx_active_d;
	logic       tx_level_q, tx_level_d;

	logic [7:0] rx_shift_q, rx_shift_d;
	logic [7:0] rx_mask_q, rx_mask_d;
	logic [3:0] rx_bits_q, rx_bits_d, rx_bits_dec;
	logic [7:0] rx_cd_q, rx_cd_d, rx_cd_dec;
	logic       rx_active_q, rx_active_d;
	logic       rx_stop_q, rx_stop_d;

	logic       tx_wr, rx_wr;
	logic [7:0] tx_tail_byte, rx_tail_byte;
	logic       accepted, popped_valid;
	logic [7:0] popped;
	logic [TxPw:0] tx_cnt;
	logic [RxPw:0] rx_cnt;

	assign tx_head_inc  = (tx_head_q == TxLast) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_inc  = (tx_tail_q == TxLast) ? '0 : tx_tail_q + 1'b1;
	assign rx_head_inc  = (rx_head_q == RxLast) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_inc  = (rx_tail_q == RxLast) ? '0 : rx_tail_q + 1'b1;
	assign tx_tail_byte = tx_ring_q[tx_tail_q];
	assign rx_tail_byte = rx_ring_q[rx_tail_q];
	assign tx_cd_dec    = tx_cd_q - 8'd1;
	assign rx_cd_dec    = rx_cd_q - 8'd1;
	assign tx_bits_dec  = tx_bits_q - 4'd1;
	assign rx_bits_dec  = rx_bits_q - 4'd1;

	always_comb begin
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		rx_head_d    = rx_head_q;
		rx_tail_d    = rx_tail_q;
		tx_shift_d   = tx_shift_q;
		tx_bits_d    = tx_bits_q;
		tx_cd_d      = tx_cd_q;
		tx_active_d  = tx_active_q;
		tx_level_d   = tx_level_q;
		rx_shift_d   = rx_shift_q;
		rx_mask_d    = rx_mask_q;
		rx_bits_d    = rx_bits_q;
		rx_cd_d      = rx_cd_q;
		rx_active_d  = rx_active_q;
		rx_stop_d    = rx_stop_q;
		tx_wr        = 1'b0;
		rx_wr        = 1'b0;
		accepted     = 1'b0;
		popped_valid = 1'b0;
		popped       = 8'd0;

		unique case (item.cmd)
			tduart_pkg::CMD_TICK: begin
				// Transmitter: only busy while the ring holds the byte in flight.
				if (tx_head_q != tx_tail_q) begin
					if (!tx_active_q) begin
						tx_shift_d  = {1'b1, tx_tail_byte, 1'b0};
						tx_bits_d   = tduart_pkg::FRAME_BITS;
						tx_cd_d     = bit_period_q;
						tx_active_d = 1'b1;
					end else if (tx_cd_dec != 8'd0) begin
						tx_cd_d = tx_cd_dec;
					end else begin
						tx_level_d = tx_shift_q[0];
						tx_shift_d = {1'b0, tx_shift_q[9:1]};
						tx_cd_d    = bit_period_q;
						tx_bits_d  = tx_bits_dec;
						if (tx_bits_dec == 4'd0) begin
							tx_tail_d   = tx_tail_inc;
							tx_active_d = 1'b0;
						end
					end
				end
				// Receiver.
				if (rx_stop_q) begin
					rx_cd_d = rx_cd_dec;
					if (rx_cd_dec == 8'd0) begin
						if (rx_head_inc != rx_tail_q) begin
							rx_wr     = 1'b1;
							rx_head_d = rx_head_inc;
						end
						rx_stop_d   = 1'b0;
						rx_active_d = 1'b0;
					end
				end else if (!rx_active_q) begin
					if (!item.rx_line) begin
						rx_bits_d   = tduart_pkg::DATA_BITS;
						rx_cd_d     = bit_period_q + tduart_pkg::START_GAP;
						rx_shift_d  = 8'd0;
						rx_stop_d   = 1'b0;
						rx_mask_d   = 8'd1;
						rx_active_d = 1'b1;
					end
				end else if (rx_cd_dec != 8'd0) begin
					rx_cd_d = rx_cd_dec;
				end else begin
					if (item.rx_line) begin
						rx_shift_d = rx_shift_q | rx_mask_q;
					end
					rx_mask_d = {rx_mask_q[6:0], 1'b0};
					rx_bits_d = rx_bits_dec;
					if (rx_bits_dec == 4'd0) begin
						rx_stop_d = 1'b1;
					end
					rx_cd_d = bit_period_q;
				end
			end
			tduart_pkg::CMD_PUSH: begin
				if (tx_head_inc != tx_tail_q) begin
					tx_wr     = 1'b1;
					tx_head_d = tx_head_inc;
					accepted  = 1'b1;
				end
			end
			tduart_pkg::CMD_POP: begin
				if (rx_head_q != rx_tail_q) begin
					popped       = rx_tail_byte;
					rx_tail_d    = rx_tail_inc;
					popped_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Fill levels after this word, wrapped around the ring depth.
	assign tx_cnt = (tx_head_d >= tx_tail_d) ? {1'b0, tx_head_d} - {1'b0, tx_tail_d}
	                                         : {1'b0, tx_head_d} + TxDepthW - {1'b0, tx_tail_d};
	assign rx_cnt = (rx_head_d >= rx_tail_d) ? {1'b0, rx_head_d} - {1'b0, rx_tail_d}
	                                         : {1'b0, rx_head_d} + RxDepthW - {1'b0, rx_tail_d};

	always_comb begin
		res.tx_line       = tx_level_d;
		res.push_accepted = accepted;
		res.pop_valid     = popped_valid;
		res.rx_byte       = popped;
		res.rx_count      = 4'(rx_cnt);
		res.tx_pending    = 4'(tx_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= tduart_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			bit_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			tx_shift_q  <= '0;
			tx_bits_q   <= '0;
			tx_cd_q     <= '0;
			tx_active_q <= 1'b0;
			tx_level_q  <= 1'b1;
			rx_shift_q  <= '0;
			rx_mask_q   <= '0;
			rx_bits_q   <= '0;
			rx_cd_q     <= '0;
			rx_active_q <= 1'b0;
			rx_stop_q   <= 1'b0;
		end else if (adv) begin
			tx_head_q   <= tx_head_d;
			tx_tail_q   <= tx_tail_d;
			rx_head_q   <= rx_head_d;
			rx_tail_q   <= rx_tail_d;
			tx_shift_q  <= tx_shift_d;
			tx_bits_q   <= tx_bits_d;
			tx_cd_q     <= tx_cd_d;
			tx_active_q <= tx_active_d;
			tx_level_q  <= tx_level_d;
			rx_shift_q  <= rx_shift_d;
			rx_mask_q   <= rx_mask_d;
			rx_bits_q   <= rx_bits_d;
			rx_cd_q     <= rx_cd_d;
			rx_active_q <= rx_active_d;
			rx_stop_q   <= rx_stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tx_wr) begin
			tx_ring_q[tx_head_q] <= item.tx_byte;
		end
		if (adv && rx_wr) begin
			rx_ring_q[rx_head_q] <= rx_shift_q;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tick_driven_uart_with_fifos.sv
// ----------------------------------------------------------------------------
// Tick-paced 8N1 UART with FIFOs
// Ticks, transmit pushes and receive pops arrive as stream words; each word
// returns one status word.
// ----------------------------------------------------------------------------
// Channel | Direction | Carries
// s_*     | in        | tuser[1:0] cmd; tdata rx_line, tx_byte
// m_*     | out       | tdata tx_line, push_accepted, pop_valid, rx_byte,
//         |           |       rx_count, tx_pending
// cfg_*   | in        | bit_period, written on cfg_we
//
// One word is accepted every cycle while s_tready is high; each result passes
// through the input register, then the result register, before it is presented.
// The whole UART state updates together from the registered word.
// Reset clears pointers and control state at once; ring contents start
// undefined and are never read before being written.
// A two-entry result buffer keeps accepting while m_tready is low; s_tready
// drops only once both entries and the input register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_driven_uart_with_fifos (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// rx_line, tx_byte, zero padding
	input  wire logic [tduart_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd
	input  wire logic [tduart_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// tx_line, push_accepted, pop_valid, rx_byte, rx_count, tx_pending, padding
	output logic [tduart_pkg::OUT_DATA_W-1:0]         m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [7:0]                           cfg_wdata
);

	logic                v_s1;
	tduart_pkg::item_t   item_s1;
	logic                ob_ready;
	logic                adv;
	tduart_pkg::result_t core_res;
	tduart_pkg::result_t out_res;

	assign adv      = v_s1 && ob_ready;
	assign s_tready = !v_s1 || ob_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd     <= s_tuser;
			item_s1.rx_line <= s_tdata[0];
			item_s1.tx_byte <= s_tdata[8:1];
		end
	end

	tduart_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (adv),
		.item      (item_s1),
		.res       (core_res)
	);

	tduart_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (ob_ready),
		.in_res    (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {(tduart_pkg::OUT_DATA_W - tduart_pkg::RESULT_W)'(0), out_res};

endmodule

`default_nettype wire

FILE: hw/rtl/tduart_chk.sv
// ----------------------------------------------------------------------------
// UART port checker
// Watches the result stream of the UART and is bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_driven_uart_with_fifos_macros.svh"

module tduart_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [tduart_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result word must stay put.
	`TDU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// One word is either a push or a pop, never both.
	`TDU_ASSERT_SAME(a_push_pop_excl, m_tvalid, !(m_tdata[1] && m_tdata[2]), "push and pop flagged in one word")

	// Without a popped byte the byte field reads zero.
	`TDU_ASSERT_SAME(a_no_pop_zero, m_tvalid && !m_tdata[2], m_tdata[10:3] == 8'd0, "rx_byte non-zero without pop")

	// A successful pop cannot leave the receive ring full.
	`TDU_ASSERT_SAME(a_pop_room, m_tvalid && m_tdata[2], m_tdata[14:11] != 4'd15, "receive ring full after pop")

endmodule

bind tick_driven_uart_with_fifos tduart_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART block regression
// Drives ticks, transmit pushes and receive pops into the stream port and
// checks every status word against a cycle-free model of the transmitter,
// the receiver and both rings kept inside this bench. Directed tests cover
// idle ticks, the unused command, full and empty rings and the extreme bit
// periods. Random traffic then feeds well-formed serial frames with host
// accesses mixed in, plus line noise, under several bit periods.
// ----------------------------------------------------------------------------

module tb;
	import tduart_pkg::*;

	localparam logic [1:0] CMD_UNUSED     = 2'd3;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [7:0]            cfg_wdata = '0;

	always #2 clk = ~clk;

	tick_driven_uart_with_fifos dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Model state: configuration, both rings and both serial engines.
	logic [7:0] period_q;
	logic [7:0] txr_mem [TX_RING_DEPTH];
	logic [7:0] rxr_mem [RX_RING_DEPTH];
	int         txr_head, txr_tail, rxr_head, rxr_tail;
	logic [9:0] txf_shift;
	logic [3:0] txf_left;
	logic [7:0] txf_cnt;
	logic       txf_busy, txf_level;
	logic [7:0] rxf_shift, rxf_mask, rxf_cnt;
	logic [3:0] rxf_left;
	logic       rxf_busy, rxf_stop;

	result_t status_q [$];
	int      status_errors = 0;
	int      words_sent    = 0;
	int      burst_left    = 0;
	int      stuck_cycles  = 0;

	// Advances the model by one word and returns the status word it should give.
	task automatic uart_step(input logic [1:0] cmd, input logic line, input logic [7:0] data,
			output result_t res);
		res = '0;
		case (cmd)
			CMD_TICK: begin
				if (txr_head != txr_tail) begin
					if (!txf_busy) begin
						txf_shift = {1'b1, txr_mem[txr_tail], 1'b0};
						txf_left  = FRAME_BITS;
						txf_cnt   = period_q;
						txf_busy  = 1'b1;
					end else begin
						txf_cnt = txf_cnt - 8'd1;
						if (txf_cnt == 8'd0) begin
							txf_level = txf_shift[0];
							txf_shift = txf_shift >> 1;
							txf_cnt   = period_q;
							txf_left  = txf_left - 4'd1;
							if (txf_left == 4'd0) begin
								txr_tail = (txr_tail + 1) % TX_RING_DEPTH;
								txf_busy = 1'b0;
							end
						end
					end
				end
				if (rxf_stop) begin
					rxf_cnt = rxf_cnt - 8'd1;
					if (rxf_cnt == 8'd0) begin
						// A byte that finds the ring full is lost.
						if ((rxr_head + 1) % RX_RING_DEPTH != rxr_tail) begin
							rxr_mem[rxr_head] = rxf_shift;
							rxr_head = (rxr_head + 1) % RX_RING_DEPTH;
						end
						rxf_stop = 1'b0;
						rxf_busy = 1'b0;
					end
				end else if (!rxf_busy) begin
					if (!line) begin
						rxf_left  = DATA_BITS;
						rxf_cnt   = period_q + START_GAP;
						rxf_shift = '0;
						rxf_mask  = 8'd1;
						rxf_busy  = 1'b1;
					end
				end else begin
					rxf_cnt = rxf_cnt - 8'd1;
					if (rxf_cnt == 8'd0) begin
						if (line)
							rxf_shift = rxf_shift | rxf_mask;
						rxf_mask = rxf_mask << 1;
						rxf_left = rxf_left - 4'd1;
						if (rxf_left == 4'd0)
							rxf_stop = 1'b1;
						rxf_cnt = period_q;
					end
				end
			end
			CMD_PUSH: begin
				if ((txr_head + 1) % TX_RING_DEPTH != txr_tail) begin
					txr_mem[txr_head] = data;
					txr_head = (txr_head + 1) % TX_RING_DEPTH;
					res.push_accepted = 1'b1;
				end
			end
			CMD_POP: begin
				if (rxr_head != rxr_tail) begin
					res.rx_byte   = rxr_mem[rxr_tail];
					res.pop_valid = 1'b1;
					rxr_tail = (rxr_tail + 1) % RX_RING_DEPTH;
				end
			end
			default: ;
		endcase
		res.tx_line    = txf_level;
		res.rx_count   = 4'((RX_RING_DEPTH + rxr_head - rxr_tail) % RX_RING_DEPTH);
		res.tx_pending = 4'((TX_RING_DEPTH + txr_head - txr_tail) % TX_RING_DEPTH);
	endtask

	// Sends one word; the sender works in bursts with idle gaps between most of them.
	task automatic send_word(input logic [1:0] cmd, input logic line, input logic [7:0] data);
		int      gap;
		result_t want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {{(IN_DATA_W - 9){1'b0}}, data, line};
		do
			@(posedge clk);
		while (!s_tready);
		uart_step(cmd, line, data, want);
		status_q.push_back(want);
		words_sent++;
	endtask

	task automatic tick(input logic line);
		send_word(CMD_TICK, line, 8'($urandom));
	endtask

	task automatic host_access;
		int pick;
		pick = $urandom_range(0, 20);
		if (pick < 10)
			send_word(CMD_PUSH, 1'($urandom), 8'($urandom));
		else if (pick < 20)
			send_word(CMD_POP, 1'($urandom), 8'($urandom));
		else
			send_word(CMD_UNUSED, 1'($urandom), 8'($urandom));
	endtask

	// Holds the sender off until every outstanding status word has come back.
	task automatic drain_status;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_bit_period(input logic [7:0] ticks);
		drain_status();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = ticks;
		@(negedge clk);
		cfg_we    = 1'b0;
		period_q  = ticks;
	endtask

	// One 8N1 frame on the receive pin, each bit held for span ticks.
	task automatic rx_frame(input logic [7:0] value, input int span, input bit mixed);
		logic [9:0] bits;
		bits = {1'b1, value, 1'b0};
		for (int b = 0; b < 10; b++)
			for (int k = 0; k < span; k++) begin
				if (mixed && $urandom_range(0, 7) == 0)
					host_access();
				tick(bits[b]);
			end
	endtask

	task automatic test_idle_and_unused;
		tick(1'b1);
		tick(1'b1);
		send_word(CMD_POP, 1'b1, 8'hFF);
		send_word(CMD_UNUSED, 1'b1, 8'hFF);
		send_word(CMD_UNUSED, 1'b0, 8'h00);
		send_word(CMD_PUSH, 1'b0, 8'h00);
		send_word(CMD_PUSH, 1'b1, 8'hFF);
	endtask

	task automatic test_tx_ring_full;
		for (int i = 0; i < 15; i++)
			send_word(CMD_PUSH, 1'($urandom), (i % 2 == 0) ? 8'hA5 : 8'($urandom));
		drain_status();
	endtask

	// Fills the receive ring, overruns it by one byte and then empties it.
	task automatic test_rx_ring_full;
		set_bit_period(8'd1);
		for (int i = 0; i < 16; i++) begin
			rx_frame((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 1, 1'b0);
			repeat (4) tick(1'b1);
		end
		for (int i = 0; i < 16; i++)
			send_word(CMD_POP, 1'($urandom), 8'($urandom));
	endtask

	// The widest legal period, and the wrapping cases of zero and above 251.
	task automatic test_extreme_periods;
		logic [7:0] ticks;
		for (int i = 0; i < 3; i++) begin
			ticks = (i == 0) ? 8'd251 : (i == 1) ? 8'd0 : 8'd255;
			set_bit_period(ticks);
			send_word(CMD_PUSH, 1'b0, 8'($urandom));
			for (int k = 0; k < ((i == 1) ? 300 : 40); k++)
				tick(k >= 16);
		end
	endtask

	task automatic test_random_traffic;
		int         budget;
		int         choice;
		int         span;
		logic [7:0] ticks;
		for (int ph = 0; ph < 5; ph++) begin
			ticks = (ph == 0) ? 8'd5 : (ph == 1) ? 8'd1 : (ph == 2) ? 8'd3 :
				(ph == 3) ? 8'd2 : 8'($urandom_range(6, 12));
			set_bit_period(ticks);
			span   = ticks;
			budget = words_sent + 80;
			while (words_sent < budget) begin
				choice = $urandom_range(0, 9);
				if (choice < 7) begin
					repeat ($urandom_range(0, 3 * span)) tick(1'b1);
					rx_frame(8'($urandom), span, 1'b1);
				end else if (choice < 9) begin
					// Line noise, which also breaks frames part way through.
					repeat ($urandom_range(1, 2 * span + 6)) begin
						if ($urandom_range(0, 5) == 0)
							host_access();
						tick(1'($urandom));
					end
				end else begin
					repeat ($urandom_range(1, 6)) host_access();
				end
			end
		end
	endtask

	// The receiver changes its stall behaviour every so often.
	int   ready_mode = 0;
	int   ready_left = 0;
	int   ready_hold = 0;
	logic ready_level = 1'b1;

	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_left = $urandom_range(20, 200);
		end
		ready_left--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (ready_hold == 0) begin
					ready_hold  = $urandom_range(1, 12);
					ready_level = ~ready_level;
				end
				ready_hold--;
				m_tready <= ready_level;
			end
		endcase
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[RESULT_W-1:0]);
			if (status_q.size() == 0) begin
				status_errors++;
				if (status_errors <= 10)
					$display("%0t: status word %h arrived with nothing outstanding",
						$time, m_tdata);
			end else begin
				want = status_q.pop_front();
				if (got !== want || m_tdata[OUT_DATA_W-1:RESULT_W] !== '0) begin
					status_errors++;
					if (status_errors <= 10)
						$display({"%0t: status mismatch, expected line %b acc %b pop %b ",
							"byte %h rxc %0d txp %0d, got line %b acc %b pop %b ",
							"byte %h rxc %0d txp %0d (word %h)"}, $time,
							want.tx_line, want.push_accepted, want.pop_valid,
							want.rx_byte, want.rx_count, want.tx_pending,
							got.tx_line, got.push_accepted, got.pop_valid,
							got.rx_byte, got.rx_count, got.tx_pending, m_tdata);
				end
			end
		end
	end

	// Ends a run that has stopped making progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stuck_cycles = 0;
		else if (++stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		period_q  = PERIOD_RESET;
		txr_head  = 0;
		txr_tail  = 0;
		rxr_head  = 0;
		rxr_tail  = 0;
		txf_shift = '0;
		txf_left  = '0;
		txf_cnt   = '0;
		txf_busy  = 1'b0;
		txf_level = 1'b1;
		rxf_shift = '0;
		rxf_mask  = '0;
		rxf_left  = '0;
		rxf_cnt   = '0;
		rxf_busy  = 1'b0;
		rxf_stop  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_idle_and_unused();
		test_tx_ring_full();
		test_rx_ring_full();
		test_extreme_periods();
		test_random_traffic();
		drain_status();
		repeat (8) @(posedge clk);
		if (status_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tduart_pkg.sv
hw/rtl/tduart_obuf.sv
hw/rtl/tduart_core.sv
hw/rtl/tick_driven_uart_with_fifos.sv
hw/rtl/tduart_chk.sv
test/tb.sv
